// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== rtl/wttq_pkg.sv =====
// ----------------------------------------------------------------------------
// wttq_pkg
// Types and codes shared by the wake-time task queue.
// ----------------------------------------------------------------------------
`default_nettype none

package wttq_pkg;

    typedef enum logic [1:0] {
        OP_SCHEDULE = 2'd0,
        OP_POP      = 2'd1,
        OP_TICK     = 2'd2,
        OP_REMOVE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_DUPLICATE   = 3'd1,
        ST_PAST        = 3'd2,
        ST_FULL        = 3'd3,
        ST_NOT_FOUND   = 3'd4,
        ST_NOTHING_DUE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    compare;
        logic    insert;
        logic    drop_match;
        logic    drop_head;
        logic    tick;
        logic    load_out;
        logic    give_match;
        logic    give_head;
        status_t status;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic dup;
        logic past;
        logic full;
        logic due;
    } flag_t;

endpackage

`default_nettype wire

// ===== rtl/wttq_if.sv =====
// ----------------------------------------------------------------------------
// wttq_req_if / wttq_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface wttq_req_if #(
    parameter int ID_WIDTH   = 16,
    parameter int TIME_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    wttq_pkg::op_t         operation;
    logic [ID_WIDTH-1:0]   task_id;
    logic [TIME_WIDTH-1:0] wake_at;

    modport source (output valid, operation, task_id, wake_at, input ready);
    modport sink   (input valid, operation, task_id, wake_at, output ready);
endinterface

interface wttq_rsp_if #(
    parameter int ID_WIDTH   = 16,
    parameter int TIME_WIDTH = 48
);
    logic                  valid;
    logic                  ready;
    wttq_pkg::status_t     status;
    logic [ID_WIDTH-1:0]   out_task_id;
    logic [TIME_WIDTH-1:0] out_wake_time;
    logic [TIME_WIDTH-1:0] current_time;

    modport source (output valid, status, out_task_id, out_wake_time, current_time,
                    input ready);
    modport sink   (input valid, status, out_task_id, out_wake_time, current_time,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/wttq_ctrl.sv =====
// ----------------------------------------------------------------------------
// wttq_ctrl
// Sequencer: capture, compare, then execute one operation.
// ----------------------------------------------------------------------------
`default_nettype none

module wttq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    input  wire wttq_pkg::flag_t flags,
    output wttq_pkg::cmd_t      cmd
);

    wttq_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wttq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == wttq_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;
        cmd.status     = wttq_pkg::ST_OK;
        unique case (state_reg)
            wttq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = wttq_pkg::S_CMP;
                end
            end
            wttq_pkg::S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = wttq_pkg::S_EXEC;
            end
            wttq_pkg::S_EXEC:
            begin
                // wait until the result register is free
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = wttq_pkg::S_IDLE;
                    unique case (flags.op)
                        wttq_pkg::OP_SCHEDULE:
                        begin
                            priority if (flags.dup)
                                cmd.status = wttq_pkg::ST_DUPLICATE;
                            else if (flags.past)
                                cmd.status = wttq_pkg::ST_PAST;
                            else if (flags.full)
                                cmd.status = wttq_pkg::ST_FULL;
                            else
                                cmd.insert = 1'b1;
                        end
                        wttq_pkg::OP_POP:
                        begin
                            if (flags.due)
                            begin
                                cmd.drop_head = 1'b1;
                                cmd.give_head = 1'b1;
                            end
                            else
                                cmd.status = wttq_pkg::ST_NOTHING_DUE;
                        end
                        wttq_pkg::OP_TICK:
                            cmd.tick = 1'b1;
                        wttq_pkg::OP_REMOVE:
                        begin
                            if (flags.dup)
                            begin
                                cmd.drop_match = 1'b1;
                                cmd.give_match = 1'b1;
                            end
                            else
                                cmd.status = wttq_pkg::ST_NOT_FOUND;
                        end
                        default: ;
                    endcase
                end
            end
            default: state_next = wttq_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/wttq_dp.sv =====
// ----------------------------------------------------------------------------
// wttq_dp
// Row of sorted shift cells, time counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wttq_dp #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_WIDTH    = 16,
    parameter int TIME_WIDTH  = 48
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire wttq_pkg::op_t         in_op,
    input  wire logic [ID_WIDTH-1:0]   in_id,
    input  wire logic [TIME_WIDTH-1:0] in_wake,
    input  wire wttq_pkg::cmd_t        cmd,
    output wttq_pkg::flag_t            flags,
    output wttq_pkg::status_t          out_status,
    output logic [ID_WIDTH-1:0]        out_id,
    output logic [TIME_WIDTH-1:0]      out_wake,
    output logic [TIME_WIDTH-1:0]      out_now
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [ID_WIDTH-1:0]   id_reg   [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] time_reg [QUEUE_DEPTH];
    logic [CW-1:0]         count_reg;
    logic [TIME_WIDTH-1:0] now_reg, now_next;

    wttq_pkg::op_t         op_reg;
    logic [ID_WIDTH-1:0]   in_id_reg;
    logic [TIME_WIDTH-1:0] in_wake_reg;

    logic [QUEUE_DEPTH-1:0] match_reg, match_next;
    logic [QUEUE_DEPTH-1:0] le_reg, le_next;
    logic [QUEUE_DEPTH-1:0] from_match_reg, from_match_next;
    logic [ID_WIDTH-1:0]    fid_reg, fid_next;
    logic [TIME_WIDTH-1:0]  fwake_reg, fwake_next;
    logic                   past_reg, due_reg;

    // per-cell compares; ids are unique so an AND-OR picks the matching entry
    always_comb
    begin
        fid_next   = '0;
        fwake_next = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            match_next[i] = (CW'(i) < count_reg) && (id_reg[i] == in_id_reg);
            le_next[i]    = (CW'(i) < count_reg) && (time_reg[i] <= in_wake_reg);
            fid_next      = fid_next   | (id_reg[i]   & {ID_WIDTH{match_next[i]}});
            fwake_next    = fwake_next | (time_reg[i] & {TIME_WIDTH{match_next[i]}});
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
            from_match_next[i] = |(match_next & ({QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - i)));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= in_op;
            in_id_reg   <= in_id;
            in_wake_reg <= in_wake;
        end
        if (cmd.compare)
        begin
            match_reg      <= match_next;
            le_reg         <= le_next;
            from_match_reg <= from_match_next;
            fid_reg        <= fid_next;
            fwake_reg      <= fwake_next;
            past_reg       <= in_wake_reg < now_reg;
            due_reg        <= (count_reg != '0) && (time_reg[0] <= now_reg);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (cmd.insert && !le_reg[i])
            begin
                if (i == 0 || le_reg[(i == 0) ? 0 : i - 1])
                begin
                    id_reg[i]   <= in_id_reg;
                    time_reg[i] <= in_wake_reg;
                end
                else
                begin
                    id_reg[i]   <= id_reg[(i == 0) ? 0 : i - 1];
                    time_reg[i] <= time_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if ((cmd.drop_head || (cmd.drop_match && from_match_reg[i]))
                     && i < QUEUE_DEPTH - 1)
            begin
                id_reg[i]   <= id_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                time_reg[i] <= time_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
        if (cmd.load_out)
        begin
            out_status <= cmd.status;
            out_now    <= now_next;
            if (cmd.give_match)
            begin
                out_id   <= fid_reg;
                out_wake <= fwake_reg;
            end
            else if (cmd.give_head)
            begin
                out_id   <= id_reg[0];
                out_wake <= time_reg[0];
            end
            else
            begin
                out_id   <= '0;
                out_wake <= '0;
            end
        end
    end

    assign now_next = cmd.tick ? now_reg + TIME_WIDTH'(1) : now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            now_reg   <= '0;
        end
        else
        begin
            now_reg <= now_next;
            if (cmd.insert)
                count_reg <= count_reg + CW'(1);
            else if (cmd.drop_head || cmd.drop_match)
                count_reg <= count_reg - CW'(1);
        end
    end

    assign flags.op   = op_reg;
    assign flags.dup  = |match_reg;
    assign flags.past = past_reg;
    assign flags.full = (count_reg == CW'(QUEUE_DEPTH));
    assign flags.due  = due_reg;

endmodule

`default_nettype wire

// ===== rtl/wake_time_task_queue.sv =====
// A request passes the compare and execute states before its result is registered.
// A new request is accepted only in idle, once the capture/compare/execute sequencer has
// finished the last one; the compare stage evaluates all queue cells in parallel.
// A pending result stalls execute until taken.
// Reset (rst_n, async low) empties the queue and clears the time counter.
// ----------------------------------------------------------------------------
// wake_time_task_queue
// Sorted queue of task ids by wake time, with a sample-time counter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wake_time_task_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_WIDTH    = 16,
    parameter int TIME_WIDTH  = 48
) (
    input  wire logic clk,
    input  wire logic rst_n,
    wttq_req_if.sink  req,
    wttq_rsp_if.source rsp
);

    wttq_pkg::cmd_t  cmd;
    wttq_pkg::flag_t flags;

    wttq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    wttq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_op      (req.operation),
        .in_id      (req.task_id),
        .in_wake    (req.wake_at),
        .cmd        (cmd),
        .flags      (flags),
        .out_status (rsp.status),
        .out_id     (rsp.out_task_id),
        .out_wake   (rsp.out_wake_time),
        .out_now    (rsp.current_time)
    );

    `ASSERT_IMPLY(a_no_insert_full, clk, rst_n, cmd.insert, !flags.full)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready, !req.ready)
    `ASSERT_NEXT(a_result_after_load, clk, rst_n, cmd.load_out, rsp.valid)

endmodule

`default_nettype wire
